// File: hdl/mvm_pkg.sv
package mvm_pkg;

   localparam int MAX_DIM = 64;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
   localparam int CNT_W   = $clog2(MAX_DIM + 1);
   localparam int DIM_W   = 7;
   localparam int ELEM_W  = 16;
   localparam int ACC_W   = 32;
   localparam int ROW_W   = 6;
   localparam int CMD_W   = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_MATRIX = 2'd0,
      CMD_WRITE_VECTOR = 2'd1,
      CMD_COMPUTE      = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic write_matrix;
      logic write_vector;
   } ctrl_type;

   typedef struct packed {
      logic stall;
      logic issue_last;
      logic pipe_busy;
   } status_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_col;
      logic             last_row;
      logic [IDX_W-1:0] row;
   } tag_type;

endpackage

// File: hdl/mvm_ctrl.sv
module mvm_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mvm_pkg::CMD_W-1:0]    req_command,
   input  mvm_pkg::status_type          status,
   output mvm_pkg::ctrl_type            ctrl
);

   mvm_pkg::state_type state_ff;
   mvm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctrl      = '0;
      case (state_ff)
         mvm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  mvm_pkg::CMD_WRITE_MATRIX: begin
                     ctrl.write_matrix = 1'b1;
                  end
                  mvm_pkg::CMD_WRITE_VECTOR: begin
                     ctrl.write_vector = 1'b1;
                  end
                  mvm_pkg::CMD_COMPUTE: begin
                     ctrl.start = 1'b1;
                     state_in   = mvm_pkg::ST_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         mvm_pkg::ST_RUN: begin
            ctrl.issue = 1'b1;
            if (!status.stall && status.issue_last) begin
               state_in = mvm_pkg::ST_DRAIN;
            end
         end
         mvm_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = mvm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mvm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/mvm_datapath.sv
module mvm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mvm_pkg::ctrl_type                   ctrl,
   output mvm_pkg::status_type                 status,
   input  logic [mvm_pkg::ROW_W-1:0]           req_row_index,
   input  logic [mvm_pkg::ROW_W-1:0]           req_col_index,
   input  logic signed [mvm_pkg::ELEM_W-1:0]   req_element_value,
   input  logic                                csr_write_enable,
   input  logic [mvm_pkg::DIM_W-1:0]           csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mvm_pkg::ROW_W-1:0]           rsp_result_row,
   output logic signed [mvm_pkg::ACC_W-1:0]    rsp_dot_product,
   output logic                                rsp_last_row
);

   logic signed [mvm_pkg::ELEM_W-1:0] matrix_store_ff [mvm_pkg::MAX_DIM*mvm_pkg::MAX_DIM];
   logic signed [mvm_pkg::ELEM_W-1:0] vector_store_ff [mvm_pkg::MAX_DIM];

   logic [mvm_pkg::DIM_W-1:0]         dimension_ff;
   logic [mvm_pkg::IDX_W-1:0]         row_ff;
   logic [mvm_pkg::IDX_W-1:0]         col_ff;
   logic [mvm_pkg::IDX_W-1:0]         row_in;
   logic [mvm_pkg::IDX_W-1:0]         col_in;
   logic signed [mvm_pkg::ELEM_W-1:0] mat_rd_ff;
   logic signed [mvm_pkg::ELEM_W-1:0] vec_rd_ff;
   logic signed [mvm_pkg::ACC_W-1:0]  prod_ff;
   logic signed [mvm_pkg::ACC_W-1:0]  prod_in;
   logic signed [mvm_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mvm_pkg::ACC_W-1:0]  acc_in;
   mvm_pkg::tag_type                  tag1_ff;
   mvm_pkg::tag_type                  tag2_ff;
   mvm_pkg::tag_type                  tag3_ff;
   mvm_pkg::tag_type                  tag1_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [mvm_pkg::ROW_W-1:0]         rsp_row_ff;
   logic signed [mvm_pkg::ACC_W-1:0]  rsp_dot_ff;
   logic                              rsp_last_ff;

   logic [mvm_pkg::CNT_W-1:0]         dim_use;
   logic [mvm_pkg::IDX_W-1:0]         idx_last;
   logic                              stall;
   logic                              issue_go;
   logic                              last_col;
   logic                              last_row;
   logic                              wr_row_ok;
   logic                              wr_col_ok;
   logic [mvm_pkg::ADDR_W-1:0]        wr_addr;
   logic [mvm_pkg::ADDR_W-1:0]        rd_addr;
   logic                              row_done;

   // dimension in use, clamped to one through the store size
   always_comb begin
      if (dimension_ff == '0) begin
         dim_use = mvm_pkg::CNT_W'(1);
      end else if (int'(dimension_ff) > mvm_pkg::MAX_DIM) begin
         dim_use = mvm_pkg::CNT_W'(mvm_pkg::MAX_DIM);
      end else begin
         dim_use = mvm_pkg::CNT_W'(dimension_ff);
      end
   end

   assign idx_last = mvm_pkg::IDX_W'(dim_use - mvm_pkg::CNT_W'(1));
   assign stall    = rsp_valid_ff && !rsp_ready;
   assign issue_go = ctrl.issue && !stall;
   assign last_col = (col_ff == idx_last);
   assign last_row = (row_ff == idx_last);

   assign wr_row_ok = int'(req_row_index) < mvm_pkg::MAX_DIM;
   assign wr_col_ok = int'(req_col_index) < mvm_pkg::MAX_DIM;
   assign wr_addr   = mvm_pkg::ADDR_W'(mvm_pkg::IDX_W'(req_row_index))
                    * mvm_pkg::ADDR_W'(mvm_pkg::MAX_DIM)
                    + mvm_pkg::ADDR_W'(mvm_pkg::IDX_W'(req_col_index));
   assign rd_addr   = mvm_pkg::ADDR_W'(row_ff) * mvm_pkg::ADDR_W'(mvm_pkg::MAX_DIM)
                    + mvm_pkg::ADDR_W'(col_ff);

   always_ff @(posedge clock) begin
      if (ctrl.write_matrix && wr_row_ok && wr_col_ok) begin
         matrix_store_ff[wr_addr] <= req_element_value;
      end
      if (issue_go) begin
         mat_rd_ff <= matrix_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write_vector && wr_col_ok) begin
         vector_store_ff[mvm_pkg::IDX_W'(req_col_index)] <= req_element_value;
      end
      if (issue_go) begin
         vec_rd_ff <= vector_store_ff[col_ff];
      end
   end

   // element counters
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (ctrl.start) begin
         row_in = '0;
         col_in = '0;
      end else if (issue_go) begin
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + mvm_pkg::IDX_W'(1);
         end else begin
            col_in = col_ff + mvm_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
   end

   always_comb begin
      tag1_in          = '0;
      tag1_in.valid    = ctrl.issue;
      tag1_in.first    = (col_ff == '0);
      tag1_in.last_col = last_col;
      tag1_in.last_row = last_row;
      tag1_in.row      = row_ff;
   end

   assign prod_in = mat_rd_ff * vec_rd_ff;
   assign acc_in  = tag2_ff.first ? prod_ff : acc_ff + prod_ff;
   assign row_done = tag3_ff.valid && tag3_ff.last_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         acc_ff  <= '0;
      end else if (!stall) begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         if (tag2_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall && tag1_ff.valid) begin
         prod_ff <= prod_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!stall && row_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall && row_done) begin
         rsp_row_ff  <= mvm_pkg::ROW_W'(tag3_ff.row);
         rsp_dot_ff  <= acc_ff;
         rsp_last_ff <= tag3_ff.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= mvm_pkg::DIM_RESET;
      end else if (csr_write_enable) begin
         dimension_ff <= csr_write_data;
      end
   end

   assign status.stall      = stall;
   assign status.issue_last = last_col && last_row;
   assign status.pipe_busy  = tag1_ff.valid || tag2_ff.valid || tag3_ff.valid;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_row  = rsp_row_ff;
   assign rsp_dot_product = rsp_dot_ff;
   assign rsp_last_row    = rsp_last_ff;

endmodule

// File: hdl/matrix_vector_multiply.sv
// Square matrix-vector product, signed 16-bit elements, 32-bit wrapping sums.
// Input channel (req_): one item per handshake. Command write-matrix stores
// element_value at (row_index, col_index), write-vector stores it at
// col_index, compute starts a run. Loads are taken one per cycle while idle.
// A run over dimension n gives n items on the rsp_ channel, one per row in
// row order, with rsp_last_row high on the final row. Every run starts its
// sums at zero.
// One multiply-accumulate unit with one matrix read port does one element
// per cycle while the receiver does not stall. Each element passes the read
// registers, the product register and the accumulator; req_ready returns once
// the last element has left the pipeline. req_ready is low during a run.
// csr_write_data sets the dimension (reset 64, zero reads as one, values
// above 64 as 64); write it only while no run is under way.
// Reset clears control state and sets the dimension to 64; the stores hold
// nothing defined until written. When the receiver stalls, the whole product
// pipeline holds until the waiting result is taken.
module matrix_vector_multiply (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mvm_pkg::CMD_W-1:0]           req_command,
   input  logic [mvm_pkg::ROW_W-1:0]           req_row_index,
   input  logic [mvm_pkg::ROW_W-1:0]           req_col_index,
   input  logic signed [mvm_pkg::ELEM_W-1:0]   req_element_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mvm_pkg::ROW_W-1:0]           rsp_result_row,
   output logic signed [mvm_pkg::ACC_W-1:0]    rsp_dot_product,
   output logic                                rsp_last_row,
   input  logic                                csr_write_enable,
   input  logic [mvm_pkg::DIM_W-1:0]           csr_write_data
);

   mvm_pkg::ctrl_type   ctrl;
   mvm_pkg::status_type status;

   mvm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (status),
      .ctrl        (ctrl)
   );

   mvm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_row    (rsp_result_row),
      .rsp_dot_product   (rsp_dot_product),
      .rsp_last_row      (rsp_last_row)
   );

endmodule

// File: hdl/matrix_vector_multiply_checker.sv
module matrix_vector_multiply_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [mvm_pkg::CMD_W-1:0]           req_command,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [mvm_pkg::ROW_W-1:0]           rsp_result_row,
   input  logic signed [mvm_pkg::ACC_W-1:0]    rsp_dot_product,
   input  logic                                rsp_last_row
);

   // out of reset: idle, nothing pending
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // a compute item closes the input channel
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == mvm_pkg::CMD_COMPUTE) |=> !req_ready)
      else $error("input still open after compute item");

   // a load item leaves the block idle and makes no result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_command == mvm_pkg::CMD_WRITE_MATRIX
       || req_command == mvm_pkg::CMD_WRITE_VECTOR)) |=> req_ready && !$rose(rsp_valid))
      else $error("load item disturbed idle state");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_dot_product)
      && $stable(rsp_result_row) && $stable(rsp_last_row))
      else $error("result changed while stalled");

endmodule

bind matrix_vector_multiply matrix_vector_multiply_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_command     (req_command),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_row  (rsp_result_row),
   .rsp_dot_product (rsp_dot_product),
   .rsp_last_row    (rsp_last_row)
);
